### hw/rtl/radio_packet_deframe_filter_defines.svh
// Assertion helpers used by rpdf_fifo
`ifndef RADIO_PACKET_DEFRAME_FILTER_DEFINES_SVH
`define RADIO_PACKET_DEFRAME_FILTER_DEFINES_SVH

// same-cycle implication
`define RPDF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpdf assertion failed");

// next-cycle implication
`define RPDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpdf assertion failed");

`endif

### hw/rtl/rpdf_pkg.sv
package rpdf_pkg;

  localparam int HEADER_BYTES          = 14;
  localparam int MAX_PAYLOAD_BYTES_DEF = 64;
  localparam int QUEUE_DEPTH_DEF       = 4;

  localparam logic [1:0] CFG_OWN_ID    = 2'd0;
  localparam logic [1:0] CFG_VERSION   = 2'd1;
  localparam logic [1:0] CFG_BCAST_ID  = 2'd2;

  typedef enum logic [2:0] {
    ST_ACCEPT   = 3'd0,
    ST_SHORT    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_TYPE     = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_ECHO     = 3'd5,
    ST_NOT_OURS = 3'd6
  } status_t;

  typedef struct packed {
    logic [15:0] own_id;
    logic [7:0]  version;
    logic [15:0] bcast_id;
  } cfg_t;

  // one queued item: classified byte plus header snapshot on packet end
  typedef struct packed {
    logic        pay;
    logic        last;
    logic        short_pkt;
    logic        over;
    logic [7:0]  data;
    logic [6:0]  plen;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] session;
    logic [15:0] sequence_no;
    logic [31:0] distance;
  } entry_t;

  function automatic logic type_known(input logic [7:0] t);
    return ((t >= 8'd1) && (t <= 8'd8)) || (t == 8'd200) || (t == 8'd201);
  endfunction

endpackage

### hw/rtl/rpdf_front.sv
module rpdf_front
  import rpdf_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  localparam logic [7:0] HDR_V   = 8'(HEADER_BYTES);
  localparam logic [7:0] MAX_V   = 8'(MAX_PAYLOAD_BYTES);
  localparam logic [7:0] PAY_END = 8'(HEADER_BYTES + MAX_PAYLOAD_BYTES);
  localparam logic [7:0] CAP_V   = 8'(HEADER_BYTES + MAX_PAYLOAD_BYTES + 1);

  logic [7:0]  byte_index;
  logic [7:0]  hdr_version, hdr_type;
  logic [15:0] hdr_src, hdr_dst, hdr_session, hdr_sequence;
  logic [31:0] hdr_distance;

  logic [7:0]  version_next, type_next;
  logic [15:0] src_next, dst_next, session_next, sequence_next;
  logic [31:0] distance_next;
  logic [7:0]  total, plen_full;
  logic        accept, pay, over;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    version_next  = hdr_version;
    type_next     = hdr_type;
    src_next      = hdr_src;
    dst_next      = hdr_dst;
    session_next  = hdr_session;
    sequence_next = hdr_sequence;
    distance_next = hdr_distance;
    unique case (byte_index)
      8'd0:  version_next          = in_data;
      8'd1:  type_next             = in_data;
      8'd2:  src_next[7:0]         = in_data;
      8'd3:  src_next[15:8]        = in_data;
      8'd4:  dst_next[7:0]         = in_data;
      8'd5:  dst_next[15:8]        = in_data;
      8'd6:  session_next[7:0]     = in_data;
      8'd7:  session_next[15:8]    = in_data;
      8'd8:  sequence_next[7:0]    = in_data;
      8'd9:  sequence_next[15:8]   = in_data;
      8'd10: distance_next[7:0]    = in_data;
      8'd11: distance_next[15:8]   = in_data;
      8'd12: distance_next[23:16]  = in_data;
      8'd13: distance_next[31:24]  = in_data;
      default: ;
    endcase
  end

  assign pay       = (byte_index >= HDR_V) && (byte_index < PAY_END);
  assign total     = (byte_index >= CAP_V) ? CAP_V : byte_index + 8'd1;
  assign over      = total > PAY_END;
  assign plen_full = over ? MAX_V : total - HDR_V;

  assign push = accept && (pay || in_last);

  always_comb begin
    push_entry             = '0;
    push_entry.pay         = pay;
    push_entry.last        = in_last;
    push_entry.short_pkt   = total < HDR_V;
    push_entry.over        = over;
    push_entry.data        = in_data;
    push_entry.plen        = plen_full[6:0];
    push_entry.version     = version_next;
    push_entry.msg_type    = type_next;
    push_entry.src         = src_next;
    push_entry.dst         = dst_next;
    push_entry.session     = session_next;
    push_entry.sequence_no = sequence_next;
    push_entry.distance    = distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      hdr_version  <= '0;
      hdr_type     <= '0;
      hdr_src      <= '0;
      hdr_dst      <= '0;
      hdr_session  <= '0;
      hdr_sequence <= '0;
      hdr_distance <= '0;
    end else if (accept) begin
      if (in_last) begin
        byte_index   <= '0;
        hdr_version  <= '0;
        hdr_type     <= '0;
        hdr_src      <= '0;
        hdr_dst      <= '0;
        hdr_session  <= '0;
        hdr_sequence <= '0;
        hdr_distance <= '0;
      end else begin
        byte_index   <= total;
        hdr_version  <= version_next;
        hdr_type     <= type_next;
        hdr_src      <= src_next;
        hdr_dst      <= dst_next;
        hdr_session  <= session_next;
        hdr_sequence <= sequence_next;
        hdr_distance <= distance_next;
      end
    end
  end

endmodule

### hw/rtl/rpdf_fifo.sv
`include "radio_packet_deframe_filter_defines.svh"

module rpdf_fifo
  import rpdf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  entry_t          store [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full      = count == DEPTH_C;
  assign not_empty = count != '0;
  assign head      = store[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  `RPDF_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= DEPTH_C)
  `RPDF_ASSERT_NEXT(a_fill, clk, rst, do_push && !do_pop, count == $past(count) + CW'(1))
  `RPDF_ASSERT_NEXT(a_drain, clk, rst, do_pop && !do_push, count == $past(count) - CW'(1))
  `RPDF_ASSERT_NOW(a_ptrs_meet, clk, rst, count == '0 || count == DEPTH_C, wr_ptr == rd_ptr)

endmodule

### hw/rtl/rpdf_back.sv
module rpdf_back
  import rpdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         head_valid,
  input  entry_t       head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [127:0] out_data,
  output logic [1:0]   out_user
);

  status_t      status;
  logic         hdr_ok;
  logic [127:0] data_next;

  always_comb begin
    priority if (!head.last) begin
      status = ST_ACCEPT;
    end else if (head.short_pkt) begin
      status = ST_SHORT;
    end else if (head.version != cfg.version) begin
      status = ST_VERSION;
    end else if (!type_known(head.msg_type)) begin
      status = ST_TYPE;
    end else if (head.over) begin
      status = ST_TOO_LONG;
    end else if (head.src == cfg.own_id) begin
      status = ST_ECHO;
    end else if (head.dst != cfg.bcast_id && head.dst != cfg.own_id) begin
      status = ST_NOT_OURS;
    end else begin
      status = ST_ACCEPT;
    end
  end

  assign hdr_ok = head.last && !head.short_pkt;

  always_comb begin
    data_next = '0;
    if (head.pay) begin
      data_next[7:0] = head.data;
    end
    if (hdr_ok) begin
      data_next[15:8]    = head.msg_type;
      data_next[31:16]   = head.src;
      data_next[47:32]   = head.dst;
      data_next[63:48]   = head.session;
      data_next[79:64]   = head.sequence_no;
      data_next[111:80]  = head.distance;
      data_next[118:112] = head.plen;
    end
    data_next[121:119] = status;
  end

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= data_next;
      out_user <= {head.last, head.pay};
    end
  end

endmodule

### hw/rtl/radio_packet_deframe_filter.sv
// Packet deframer and address filter. Takes one received byte per cycle with
// s_tlast on the packet's final byte; bytes past the 14-byte header come out
// at once as tentative payload (up to MAX_PAYLOAD_BYTES), and the final byte
// also brings the verdict with header fields, payload length and status.
// Header capture is combinational ahead of a QUEUE_DEPTH item queue; the
// status checks run on the queue head and feed a registered output stage.
// Items sustain one per cycle while m_tready is held high; an accepted item
// is written into the queue and then registered into the output stage;
// s_tready drops only while the queue is full. Configuration writes are taken
// in any cycle and should be made only while no packet is in flight.
module radio_packet_deframe_filter
  import rpdf_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,  // [7:0] data_byte
  input  logic         s_tlast,  // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] payload_byte, [15:8] msg_type, [31:16] src_id, [47:32] dst_id,
  // [63:48] session_id, [79:64] sequence_no, [111:80] distance_cm,
  // [118:112] payload_len, [121:119] status, [127:122] zero
  output logic [127:0] m_tdata,
  output logic [1:0]   m_tuser,  // [0] payload_valid, [1] verdict_valid
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t   cfg;
  entry_t push_entry, head;
  logic   push, q_full, pop, head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id   <= 16'd1;
      cfg.version  <= 8'd1;
      cfg.bcast_id <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_ID:   cfg.own_id   <= cfg_data;
        CFG_VERSION:  cfg.version  <= cfg_data[7:0];
        CFG_BCAST_ID: cfg.bcast_id <= cfg_data;
        default: ;
      endcase
    end
  end

  rpdf_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  rpdf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .not_empty (head_valid),
    .head      (head)
  );

  rpdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule
